// File: design/odma_pkg.sv
// Shared constants for the OAM DMA engine.
package odma_pkg;

   localparam int unsigned TRANSFER_LENGTH_DEFAULT = 160;

   localparam int unsigned ADDR_W  = 16;
   localparam int unsigned PAGE_W  = 8;
   localparam int unsigned INDEX_W = 8;

   // Memory map boundaries.
   localparam logic [ADDR_W-1:0] VRAM_BASE = 16'h8000;
   localparam logic [ADDR_W-1:0] VRAM_END  = 16'hA000;
   localparam logic [ADDR_W-1:0] ECHO_BASE = 16'hE000;
   localparam logic [ADDR_W-1:0] ECHO_FOLD = 16'h2000;
   localparam logic [ADDR_W-1:0] OAM_BASE  = 16'hFE00;
   localparam logic [ADDR_W-1:0] IO_BASE   = 16'hFF00;

endpackage

// File: design/odma_if.sv
// Request and response channel interfaces of the OAM DMA engine.
interface odma_req_if
   import odma_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [ADDR_W-1:0]   cpu_address;
   logic                start_write;
   logic [PAGE_W-1:0]   start_page;

   modport source (output valid, cpu_address, start_write, start_page, input ready);
   modport sink   (input valid, cpu_address, start_write, start_page, output ready);
endinterface

interface odma_rsp_if
   import odma_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                copy_valid;
   logic [ADDR_W-1:0]   copy_source;
   logic [INDEX_W-1:0]  oam_index;
   logic                cpu_blocked;
   logic [PAGE_W-1:0]   page_readback;

   modport source (output valid, copy_valid, copy_source, oam_index, cpu_blocked,
                   page_readback, input ready);
   modport sink   (input valid, copy_valid, copy_source, oam_index, cpu_blocked,
                   page_readback, output ready);
endinterface

// File: design/oam_dma_engine_with_bus_blocking_top.sv
// OAM DMA engine with CPU bus blocking: top level.
//
// Each request on req is one machine cycle: the CPU access address, and a
// start-register write flag with its page value. For every request exactly
// one response is produced on rsp: whether a byte is copied this cycle, its
// folded source address and OAM index, whether the CPU access is blocked,
// and the start register readback.
// A start write opens the transfer on the next request (a start-up cycle
// that copies nothing of the new transfer); bytes follow one per request
// until TRANSFER_LENGTH bytes are done. A restart replaces a running one.
// The response is registered: it sits in the output register the cycle
// after the request is taken. Throughput is one request per cycle unless
// rsp stalls; all work is a short add/compare path to the output register.
// req.ready is high whenever the output register is empty or being drained,
// so a stalled receiver holds the response and back-pressures req.
// Synchronous reset clears the transfer state, the start register and the
// output valid flag; no transfer is active after reset.
module oam_dma_engine_with_bus_blocking_top
   import odma_pkg::*;
#(
   parameter int unsigned TRANSFER_LENGTH = TRANSFER_LENGTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   odma_req_if.sink    req,
   odma_rsp_if.source  rsp
);

   localparam logic [INDEX_W:0] LEN = (INDEX_W+1)'(TRANSFER_LENGTH);

   // transfer state
   logic                active_ff,   active_in;
   logic [INDEX_W-1:0]  index_ff,    index_in;
   logic [PAGE_W-1:0]   src_page_ff, src_page_in;
   logic [PAGE_W-1:0]   pend_page_ff, pend_page_in;
   logic                pending_ff,  pending_in;
   logic [PAGE_W-1:0]   page_reg_ff, page_reg_in;

   // response register
   logic                rsp_valid_ff;
   logic                copy_valid_ff;
   logic [ADDR_W-1:0]   copy_source_ff;
   logic [INDEX_W-1:0]  oam_index_ff;
   logic                blocked_ff;
   logic [PAGE_W-1:0]   readback_ff;

   logic                accept;
   logic [ADDR_W-1:0]   raw_source;
   logic [ADDR_W-1:0]   fold_source;
   logic [INDEX_W:0]    next_index;
   logic                src_in_vram;
   logic                addr_oam;
   logic                addr_vram;
   logic                addr_ext;
   logic                blocked;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   assign raw_source  = {src_page_ff, index_ff};
   assign fold_source = (raw_source >= ECHO_BASE) ? raw_source - ECHO_FOLD : raw_source;
   assign next_index  = {1'b0, index_ff} + (INDEX_W+1)'(1);

   assign src_in_vram = (fold_source >= VRAM_BASE) && (fold_source < VRAM_END);
   assign addr_oam    = (req.cpu_address >= OAM_BASE) && (req.cpu_address < IO_BASE);
   assign addr_vram   = (req.cpu_address >= VRAM_BASE) && (req.cpu_address < VRAM_END);
   assign addr_ext    = (req.cpu_address < VRAM_BASE)
                     || ((req.cpu_address >= VRAM_END) && (req.cpu_address < OAM_BASE));
   assign blocked     = active_ff && (addr_oam || (src_in_vram ? addr_vram : addr_ext));

   always_comb begin
      active_in    = active_ff;
      index_in     = index_ff;
      src_page_in  = src_page_ff;
      pend_page_in = pend_page_ff;
      pending_in   = 1'b0;
      page_reg_in  = page_reg_ff;
      if (active_ff) begin
         index_in = next_index[INDEX_W-1:0];
         if (next_index >= LEN) begin
            active_in = 1'b0;
         end
      end
      // start-up cycle: the new transfer replaces the old one
      if (pending_ff) begin
         active_in   = 1'b1;
         index_in    = '0;
         src_page_in = pend_page_ff;
      end
      if (req.start_write) begin
         page_reg_in  = req.start_page;
         pend_page_in = req.start_page;
         pending_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         index_ff     <= '0;
         src_page_ff  <= '0;
         pend_page_ff <= '0;
         pending_ff   <= 1'b0;
         page_reg_ff  <= '0;
      end else if (accept) begin
         active_ff    <= active_in;
         index_ff     <= index_in;
         src_page_ff  <= src_page_in;
         pend_page_ff <= pend_page_in;
         pending_ff   <= pending_in;
         page_reg_ff  <= page_reg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         copy_valid_ff  <= active_ff;
         copy_source_ff <= active_ff ? fold_source : '0;
         oam_index_ff   <= active_ff ? index_ff : '0;
         blocked_ff     <= blocked;
         readback_ff    <= page_reg_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.copy_valid    = copy_valid_ff;
   assign rsp.copy_source   = copy_source_ff;
   assign rsp.oam_index     = oam_index_ff;
   assign rsp.cpu_blocked   = blocked_ff;
   assign rsp.page_readback = readback_ff;

endmodule
